@@ hw/rtl/fbha_pkg.sv @@
// Package: widths, codes and defaults shared by the hole allocator files.
`default_nettype none
package fbha_pkg;
    localparam int DEF_MAX_HOLES = 16;
    localparam int DEF_SIZE_BITS = 16;

    localparam int KIND_W     = 2;
    localparam int HIDX_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int HNUM_W     = 5;
    localparam int MODE_W     = 2;
    localparam int HCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 1'd1;

    localparam logic [HCNT_W-1:0] HOLE_COUNT_RST = 5'd16;
endpackage
`default_nettype wire

@@ hw/rtl/fbha_if.sv @@
// Interfaces: request and response channels of the hole allocator.
`default_nettype none
interface fbha_req_if
    import fbha_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [HIDX_W-1:0] hole_index;
    logic [SIZE_W-1:0] size_value;

    modport source (output valid, kind, hole_index, size_value, input ready);
    modport sink   (input valid, kind, hole_index, size_value, output ready);
endinterface

interface fbha_rsp_if
    import fbha_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              granted;
    logic [HNUM_W-1:0] hole_number;

    modport source (output valid, granted, hole_number, input ready);
    modport sink   (input valid, granted, hole_number, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fbha_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module fbha_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ hw/rtl/fbha_ctrl.sv @@
// Sequencer: config registers, list init, restore, bubble sort, scan and result register.
`default_nettype none
module fbha_ctrl
    import fbha_pkg::*;
#(
    parameter int MAX_HOLES = DEF_MAX_HOLES,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    fbha_req_if.sink                                    req,
    fbha_rsp_if.source                                  rsp,
    input  wire logic                                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                  cfg_data,
    output logic                                        orig_we,
    output logic [$clog2(MAX_HOLES)-1:0]                orig_waddr,
    output logic [SIZE_BITS-1:0]                        orig_wdata,
    output logic [$clog2(MAX_HOLES)-1:0]                orig_raddr,
    input  wire logic [SIZE_BITS-1:0]                   orig_rdata,
    output logic                                        list_we,
    output logic [$clog2(MAX_HOLES)-1:0]                list_waddr,
    output logic [$clog2(MAX_HOLES)+SIZE_BITS-1:0]      list_wdata,
    output logic [$clog2(MAX_HOLES)-1:0]                list_raddr,
    input  wire logic [$clog2(MAX_HOLES)+SIZE_BITS-1:0] list_rdata
);
    localparam int IDX_W = $clog2(MAX_HOLES);
    localparam int ENT_W = IDX_W + SIZE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_HOLES - 1);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_RS_RD    = 4'd2;
    localparam logic [3:0] S_RS_WR    = 4'd3;
    localparam logic [3:0] S_SO_START = 4'd4;
    localparam logic [3:0] S_SO_FIRST = 4'd5;
    localparam logic [3:0] S_SO_RD    = 4'd6;
    localparam logic [3:0] S_SO_CMP   = 4'd7;
    localparam logic [3:0] S_SO_END   = 4'd8;
    localparam logic [3:0] S_SC_RD    = 4'd9;
    localparam logic [3:0] S_SC_CHK   = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [HCNT_W-1:0]   hcount_reg;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    lim_reg, lim_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [ENT_W-1:0]    carry_reg, carry_next;
    logic                out_valid_reg, out_valid_next;
    logic                granted_reg, granted_next;
    logic [HNUM_W-1:0]   hnum_reg, hnum_next;

    logic                accept;
    logic [31:0]         n_int;
    logic [SIZE_BITS-1:0] ent_rem;
    logic [IDX_W-1:0]    ent_hole;
    logic                hit;
    logic                slot_free;

    assign accept    = req.valid && req.ready;
    assign ent_rem   = list_rdata[SIZE_BITS-1:0];
    assign ent_hole  = list_rdata[ENT_W-1:SIZE_BITS];
    assign hit       = ent_rem >= size_reg;
    assign slot_free = !out_valid_reg || rsp.ready;

    assign req.ready       = state_reg == S_IDLE;
    assign rsp.valid       = out_valid_reg;
    assign rsp.granted     = granted_reg;
    assign rsp.hole_number = hnum_reg;

    always_comb
    begin
        if (hcount_reg == '0)
        begin
            n_int = 32'd1;
        end
        else if (32'(hcount_reg) > 32'(MAX_HOLES))
        begin
            n_int = 32'(MAX_HOLES);
        end
        else
        begin
            n_int = 32'(hcount_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= FIT_FIRST;
            hcount_reg <= HOLE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_HOLE_COUNT: hcount_reg <= cfg_data[HCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        last_next      = last_reg;
        size_next      = size_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        granted_next   = granted_reg;
        hnum_next      = hnum_reg;
        orig_we        = 1'b0;
        orig_waddr     = IDX_W'(req.hole_index);
        orig_wdata     = SIZE_BITS'(req.size_value);
        orig_raddr     = cnt_reg;
        list_we        = 1'b0;
        list_waddr     = cnt_reg;
        list_wdata     = {cnt_reg, {SIZE_BITS{1'b0}}};
        list_raddr     = cnt_reg;

        unique case (state_reg)
            S_INIT:
            begin
                list_we = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        KIND_LOAD:
                        begin
                            orig_we = 32'(req.hole_index) < 32'(MAX_HOLES);
                        end
                        KIND_RESTORE:
                        begin
                            cnt_next   = '0;
                            state_next = S_RS_RD;
                        end
                        KIND_ALLOC:
                        begin
                            size_next = SIZE_BITS'(req.size_value);
                            last_next = IDX_W'(n_int - 32'd1);
                            lim_next  = IDX_W'(n_int - 32'd1);
                            if ((mode_reg == FIT_BEST || mode_reg == FIT_WORST)
                                && n_int > 32'd1)
                            begin
                                state_next = S_SO_START;
                            end
                            else
                            begin
                                cnt_next   = (mode_reg == FIT_WORST) ?
                                             IDX_W'(n_int - 32'd1) : '0;
                                state_next = S_SC_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RS_RD:
            begin
                state_next = S_RS_WR;
            end
            S_RS_WR:
            begin
                list_we    = 1'b1;
                list_wdata = {cnt_reg, orig_rdata};
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_RS_RD;
                end
            end
            S_SO_START:
            begin
                list_raddr = '0;
                cnt_next   = '0;
                state_next = S_SO_FIRST;
            end
            S_SO_FIRST:
            begin
                carry_next = list_rdata;
                state_next = S_SO_RD;
            end
            S_SO_RD:
            begin
                list_raddr = cnt_reg + 1'b1;
                state_next = S_SO_CMP;
            end
            S_SO_CMP:
            begin
                list_we = 1'b1;
                if (carry_reg[SIZE_BITS-1:0] > ent_rem)
                begin
                    list_wdata = list_rdata;
                end
                else
                begin
                    list_wdata = carry_reg;
                    carry_next = list_rdata;
                end
                cnt_next   = cnt_reg + 1'b1;
                state_next = (cnt_reg + 1'b1 == lim_reg) ? S_SO_END : S_SO_RD;
            end
            S_SO_END:
            begin
                list_we    = 1'b1;
                list_wdata = carry_reg;
                if (lim_reg == IDX_W'(1))
                begin
                    cnt_next   = (mode_reg == FIT_WORST) ? last_reg : '0;
                    state_next = S_SC_RD;
                end
                else
                begin
                    lim_next   = lim_reg - 1'b1;
                    state_next = S_SO_START;
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                if (hit || mode_reg == FIT_WORST || cnt_reg == last_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        granted_next   = hit;
                        hnum_next      = hit ? HNUM_W'({1'b0, ent_hole} + 1'b1) : '0;
                        list_we        = hit;
                        list_wdata     = {ent_hole, ent_rem - size_reg};
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SC_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg     <= lim_next;
        last_reg    <= last_next;
        size_reg    <= size_next;
        carry_reg   <= carry_next;
        granted_reg <= granted_next;
        hnum_reg    <= hnum_next;
    end

    a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !granted_reg |-> hnum_reg == '0)
        else $error("refused word carries a hole number");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && granted_reg |-> hnum_reg != '0)
        else $error("granted word carries hole number zero");

    a_rise_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_SC_CHK)
        else $error("response raised outside scan check");

    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == KIND_ALLOC |=> !req.ready)
        else $error("request taken while allocation in progress");
endmodule
`default_nettype wire

@@ hw/rtl/fit_based_hole_allocator_top.sv @@
// Top level: hole allocator with original-size RAM, ordered list RAM and sequencer.
//
//  channel | dir | handshake          | word
//  req     | in  | valid/ready        | kind, hole_index, size_value
//  rsp     | out | valid/ready        | granted, hole_number
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// Load writes one original size. Restore copies the original sizes into the list in
// hole order, a read then a write per entry. Allocate reads and checks each entry
// scanned; best and worst fit first bubble-sort the list in RAM, passes of length
// n-1 down to 1 (n holes in use). After reset the list RAM is set to hole order,
// req not ready. A pending response stalls only the end of an allocation.
`default_nettype none
module fit_based_hole_allocator_top
    import fbha_pkg::*;
#(
    parameter int MAX_HOLES = DEF_MAX_HOLES,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    fbha_req_if.sink                   req,
    fbha_rsp_if.source                 rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int IDX_W = $clog2(MAX_HOLES);
    localparam int ENT_W = IDX_W + SIZE_BITS;

    logic                 orig_we;
    logic [IDX_W-1:0]     orig_waddr;
    logic [SIZE_BITS-1:0] orig_wdata;
    logic [IDX_W-1:0]     orig_raddr;
    logic [SIZE_BITS-1:0] orig_rdata;
    logic                 list_we;
    logic [IDX_W-1:0]     list_waddr;
    logic [ENT_W-1:0]     list_wdata;
    logic [IDX_W-1:0]     list_raddr;
    logic [ENT_W-1:0]     list_rdata;

    fbha_ram #(.DEPTH(MAX_HOLES), .WIDTH(SIZE_BITS)) u_orig (
        .clk   (clk),
        .we    (orig_we),
        .waddr (orig_waddr),
        .wdata (orig_wdata),
        .raddr (orig_raddr),
        .rdata (orig_rdata)
    );

    fbha_ram #(.DEPTH(MAX_HOLES), .WIDTH(ENT_W)) u_list (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    fbha_ctrl #(.MAX_HOLES(MAX_HOLES), .SIZE_BITS(SIZE_BITS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .orig_we    (orig_we),
        .orig_waddr (orig_waddr),
        .orig_wdata (orig_wdata),
        .orig_raddr (orig_raddr),
        .orig_rdata (orig_rdata),
        .list_we    (list_we),
        .list_waddr (list_waddr),
        .list_wdata (list_wdata),
        .list_raddr (list_raddr),
        .list_rdata (list_rdata)
    );
endmodule
`default_nettype wire

@@ bench/tb_fit_based_hole_allocator_top.sv @@
// Testbench: directed table then random words against a hole allocator predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_fit_based_hole_allocator_top;
    import fbha_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [HIDX_W-1:0] hole_index;
        logic [SIZE_W-1:0] size_value;
    } req_word_t;

    typedef struct packed {
        logic              granted;
        logic [HNUM_W-1:0] hole_number;
    } grant_t;

    typedef struct {
        req_word_t word;
        bit        typed;
        grant_t    answer;
    } table_row_t;

    localparam int NHOLES     = 16;
    localparam int CYCLE_CAP  = 4000000;
    localparam int SETTLE     = 400;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fbha_req_if req ();
    fbha_rsp_if rsp ();

    fit_based_hole_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [MODE_W-1:0] pm_mode;
    logic [HCNT_W-1:0] pm_count;
    logic [SIZE_W-1:0] pm_orig [NHOLES];
    logic [SIZE_W-1:0] pm_left [NHOLES];
    logic [HIDX_W-1:0] pm_list [NHOLES];

    grant_t grants_due [$];
    bit     any_fail = 1'b0;
    int     cycles = 0;
    bit     stall_rsp = 1'b0;

    function automatic void predict_grant(input req_word_t w, output bit made,
                                          output grant_t g);
        int n;
        int pos;
        bit hit;
        logic [HIDX_W-1:0] t;
        logic [HIDX_W-1:0] h;
        made = 1'b0;
        g = '0;
        hit = 1'b0;
        pos = 0;
        case (w.kind)
            KIND_LOAD: pm_orig[w.hole_index] = w.size_value;
            KIND_RESTORE:
            begin
                for (int i = 0; i < NHOLES; i++)
                begin
                    pm_left[i] = pm_orig[i];
                    pm_list[i] = HIDX_W'(i);
                end
            end
            KIND_ALLOC:
            begin
                made = 1'b1;
                n = (pm_count < 1) ? 1 : (pm_count > NHOLES) ? NHOLES : pm_count;
                if (pm_mode == FIT_BEST || pm_mode == FIT_WORST)
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j + 1 + i < n; j++)
                            if (pm_left[pm_list[j]] > pm_left[pm_list[j+1]])
                            begin
                                t = pm_list[j];
                                pm_list[j] = pm_list[j+1];
                                pm_list[j+1] = t;
                            end
                if (pm_mode == FIT_WORST)
                begin
                    if (pm_left[pm_list[n-1]] >= w.size_value)
                    begin
                        hit = 1'b1;
                        pos = n - 1;
                    end
                end
                else
                begin
                    for (int j = 0; j < n && !hit; j++)
                        if (pm_left[pm_list[j]] >= w.size_value)
                        begin
                            hit = 1'b1;
                            pos = j;
                        end
                end
                if (hit)
                begin
                    h = pm_list[pos];
                    pm_left[h] = pm_left[h] - w.size_value;
                    g.granted = 1'b1;
                    g.hole_number = HNUM_W'(h) + HNUM_W'(1);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FIT_MODE)
            pm_mode = val[MODE_W-1:0];
        else
            pm_count = val;
    endtask

    task automatic send_word(input req_word_t w, input bit typed, input grant_t g);
        bit made;
        grant_t p;
        if ($urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= w.kind;
        req.hole_index <= w.hole_index;
        req.size_value <= w.size_value;
        do
            @(posedge clk);
        while (!req.ready);
        predict_grant(w, made, p);
        if (made)
        begin
            if (typed && p !== g)
            begin
                $display("%0t table row expected %p, predictor %p", $time, g, p);
                any_fail = 1'b1;
            end
            grants_due.push_back(p);
        end
    endtask

    task automatic drain;
        req.valid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        grant_t want;
        cycles <= cycles + 1;
        if (cycles % 64 < 32)
            stall_rsp <= 1'b0;
        else
            stall_rsp <= ($urandom_range(0, 2) == 0);
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (grants_due.size() == 0)
            begin
                $display("%0t unexpected word granted=%0d hole=%0d", $time,
                         rsp.granted, rsp.hole_number);
                any_fail = 1'b1;
            end
            else
            begin
                want = grants_due.pop_front();
                if (rsp.granted !== want.granted)
                begin
                    $display("%0t granted expected %0d actual %0d", $time,
                             want.granted, rsp.granted);
                    any_fail = 1'b1;
                end
                if (rsp.hole_number !== want.hole_number)
                begin
                    $display("%0t hole_number expected %0d actual %0d", $time,
                             want.hole_number, rsp.hole_number);
                    any_fail = 1'b1;
                end
            end
        end
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    assign rsp.ready = !stall_rsp;

    function automatic req_word_t mk(input logic [KIND_W-1:0] k,
                                     input int idx, input int sz);
        req_word_t w;
        w.kind = k;
        w.hole_index = HIDX_W'(idx);
        w.size_value = SIZE_W'(sz);
        return w;
    endfunction

    function automatic grant_t gr(input bit ok, input int h);
        grant_t g;
        g.granted = ok;
        g.hole_number = HNUM_W'(h);
        return g;
    endfunction

    table_row_t rows [$];

    initial
    begin
        req_word_t w;
        int mode_pick;
        int gap;
        req.valid = 1'b0;
        req.kind = KIND_LOAD;
        req.hole_index = '0;
        req.size_value = '0;
        pm_mode = FIT_FIRST;
        pm_count = HOLE_COUNT_RST;
        for (int i = 0; i < NHOLES; i++)
        begin
            pm_orig[i] = '0;
            pm_left[i] = '0;
            pm_list[i] = HIDX_W'(i);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all holes loaded first so nothing unwritten is ever read
        for (int i = 0; i < NHOLES; i++)
            rows.push_back('{mk(KIND_LOAD, i, (i == 15) ? 16'hFFFF : 100 * (i + 1)),
                             1'b0, '0});
        rows.push_back('{mk(KIND_RESTORE, 0, 0), 1'b0, '0});
        rows.push_back('{mk(KIND_ALLOC, 0, 150), 1'b1, gr(1, 2)});
        rows.push_back('{mk(KIND_ALLOC, 0, 16'hFFFF), 1'b1, gr(1, 16)});
        rows.push_back('{mk(KIND_ALLOC, 0, 16'hFFFF), 1'b1, gr(0, 0)});
        rows.push_back('{mk(KIND_ALLOC, 0, 0), 1'b1, gr(1, 1)});
        rows.push_back('{mk(KIND_SPARE, 15, 16'hFFFF), 1'b0, '0});
        rows.push_back('{mk(KIND_ALLOC, 0, 50), 1'b0, '0});
        foreach (rows[r])
            send_word(rows[r].word, rows[r].typed, rows[r].answer);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            mode_pick = (phase < 4) ? phase : $urandom_range(0, 3);
            write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode_pick));
            case (phase)
                0: write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(16));
                1: write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(1));
                2: write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(0));
                3: write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(31));
                default: write_reg(CFG_HOLE_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
            endcase
            for (int k = 0; k < 112; k++)
            begin
                gap = $urandom_range(0, 19);
                if (gap == 0)
                    w = mk(KIND_RESTORE, $urandom_range(0, 15), $urandom);
                else if (gap < 5)
                    w = mk(KIND_LOAD, $urandom_range(0, 15),
                           ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2000));
                else if (gap == 5)
                    w = mk(KIND_SPARE, $urandom_range(0, 15), $urandom);
                else
                    w = mk(KIND_ALLOC, $urandom_range(0, 15),
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 600));
                send_word(w, 1'b0, '0);
            end
            drain();
        end

        if (!any_fail)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
